[hdl/focsl_pkg.sv]
// Shared types, constants and tables of the FOC speed loop.
// Depends on nothing; the top, focsl_core and focsl_mul import it.
package focsl_pkg;

    localparam int POLE_PAIR_COUNT  = 7;
    localparam int SINE_DEPTH       = 1024;
    localparam int CORRECTION_DEPTH = 1024;
    localparam int PWM_PERIOD       = 4096;

    localparam int CORR_AW    = $clog2(CORRECTION_DEPTH);
    localparam int SIN_AW     = $clog2(SINE_DEPTH);
    localparam int QSIN_DEPTH = SINE_DEPTH / 4 + 1;
    localparam int QSIN_AW    = $clog2(QSIN_DEPTH);

    localparam logic [SIN_AW:0] SIN_Q1 = (SIN_AW + 1)'(SINE_DEPTH / 4);
    localparam logic [SIN_AW:0] SIN_Q2 = (SIN_AW + 1)'(SINE_DEPTH / 2);
    localparam logic [SIN_AW:0] SIN_Q3 = (SIN_AW + 1)'(3 * SINE_DEPTH / 4);
    localparam logic [SIN_AW:0] SIN_Q4 = (SIN_AW + 1)'(SINE_DEPTH);

    localparam logic [15:0] MECH_SCALE       = 16'(16 * POLE_PAIR_COUNT);
    localparam logic [15:0] SPEED_GAIN_RESET = 16'd3750;
    localparam longint      HALF_PI_Q30      = 64'sd1686629713;

    // shared multiplier geometry
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 26;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic signed [MUL_BW-1:0] SQRT3_HALF_Q16 = 26'sd56756;
    localparam logic signed [MUL_BW-1:0] PWM_MUL        = MUL_BW'(PWM_PERIOD);

    typedef enum logic [2:0] {
        CFG_SPEED_REF    = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_INT_GAIN     = 3'd2,
        CFG_DRIVE_MIN    = 3'd3,
        CFG_DRIVE_MAX    = 3'd4,
        CFG_ELEC_OFFSET  = 3'd5,
        CFG_FILTER_ALPHA = 3'd6,
        CFG_SPEED_GAIN   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] speed_reference;
        logic [23:0]        prop_gain;
        logic [23:0]        integral_gain_dt;
        logic signed [15:0] drive_min;
        logic signed [15:0] drive_max;
        logic [15:0]        electrical_offset;
        logic [15:0]        filter_alpha;
        logic [15:0]        speed_gain;
    } t_cfg;

    typedef struct packed {
        logic [12:0]        duty_a;
        logic [12:0]        duty_b;
        logic [12:0]        duty_c;
        logic signed [23:0] speed_estimate;
        logic signed [15:0] drive_command;
        logic [15:0]        electrical_angle;
    } t_result;

    typedef struct packed {
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_req;

    typedef enum logic [4:0] {
        S_IDLE, S_RDLO, S_RDHI, S_SAT, S_MF, S_FILT, S_MP, S_MI, S_INT, S_VQ,
        S_MS, S_MC, S_MB, S_VABC, S_MH, S_ML, S_DUTY, S_DONE
    } t_state;

    typedef logic [15:0] t_qsin [QSIN_DEPTH];

    // Quarter-wave sine, degree 13 Taylor series in Q30, rounded to Q15.
    function automatic t_qsin build_qsin();
        t_qsin  tbl;
        longint r;
        longint term;
        longint sum;
        for (int j = 0; j < QSIN_DEPTH; j++) begin
            r    = longint'(4 * j) * HALF_PI_Q30 / SINE_DEPTH;
            term = r;
            sum  = r;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 6;   sum = sum + term;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 20;  sum = sum + term;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 42;  sum = sum + term;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 72;  sum = sum + term;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 110; sum = sum + term;
            term = term * r / 1073741824; term = term * r / 1073741824;
            term = -term / 156; sum = sum + term;
            if (sum < 0) sum = 0;
            tbl[j] = 16'((sum * 32767 + 536870912) >>> 30);
        end
        return tbl;
    endfunction

    localparam t_qsin QSIN_TABLE = build_qsin();

    // Full-wave lookup folded onto the quarter table.
    function automatic logic signed [15:0] sine_at(input logic [15:0] theta);
        logic [SIN_AW:0] iw;
        logic [SIN_AW:0] j;
        logic            neg;
        logic [15:0]     q;
        iw = {1'b0, theta[15 -: SIN_AW]};
        if (iw <= SIN_Q1) begin
            j = iw;          neg = 1'b0;
        end else if (iw <= SIN_Q2) begin
            j = SIN_Q2 - iw; neg = 1'b0;
        end else if (iw <= SIN_Q3) begin
            j = iw - SIN_Q2; neg = 1'b1;
        end else begin
            j = SIN_Q4 - iw; neg = 1'b1;
        end
        q = QSIN_TABLE[j[QSIN_AW-1:0]];
        return neg ? $signed(-q) : $signed(q);
    endfunction

endpackage

[hdl/foc_speed_loop_with_angle_correction_top.sv]
// Top level of the FOC speed loop with encoder angle correction.
// Depends on focsl_pkg and focsl_core (which holds focsl_ram and focsl_mul).
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_mode, i_sensor_angle,
//                                                  i_table_index, i_table_value
//  out       output     o_out_valid / i_out_ready  o_duty_a/b/c, o_speed_estimate,
//                                                  o_drive_command, o_electrical_angle
//  cfg       input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// A table-write transaction (mode 1) is accepted while idle; the block stays ready.
// The first control tick passes through S_RDLO and S_RDHI only and stores the angle.
// Every later tick runs 22 sequencer steps, set by the 13 products that go one
// by one through the single shared multiplier, then waits in S_DONE to hand the
// result to the output register; ready returns at the edge that hands it over,
// and the next tick is accepted only from then on.
// The output register holds a result while the next tick is accepted; a tick
// that finishes while it is still full waits in the core, stalling the input.
// Reset (i_rst_n low, synchronous) clears the loop state and the configuration registers;
// the correction table is not cleared and must be loaded before the first tick.
module foc_speed_loop_with_angle_correction_top import focsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [11:0]        i_sensor_angle,
    input  logic [9:0]         i_table_index,
    input  logic signed [15:0] i_table_value,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [12:0]        o_duty_a,
    output logic [12:0]        o_duty_b,
    output logic [12:0]        o_duty_c,
    output logic signed [23:0] o_speed_estimate,
    output logic signed [15:0] o_drive_command,
    output logic [15:0]        o_electrical_angle
);

    t_cfg    r_cfg;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result core_res;
    logic    core_res_valid;
    logic    core_res_ready;

    // Configuration register file; a write lands at once, so write only while
    // no tick is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{speed_gain: SPEED_GAIN_RESET, default: '0};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_REF:    r_cfg.speed_reference   <= i_cfg_data;
                CFG_PROP_GAIN:    r_cfg.prop_gain         <= i_cfg_data;
                CFG_INT_GAIN:     r_cfg.integral_gain_dt  <= i_cfg_data;
                CFG_DRIVE_MIN:    r_cfg.drive_min         <= i_cfg_data[15:0];
                CFG_DRIVE_MAX:    r_cfg.drive_max         <= i_cfg_data[15:0];
                CFG_ELEC_OFFSET:  r_cfg.electrical_offset <= i_cfg_data[15:0];
                CFG_FILTER_ALPHA: r_cfg.filter_alpha      <= i_cfg_data[15:0];
                CFG_SPEED_GAIN:   r_cfg.speed_gain        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    focsl_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_sensor_angle (i_sensor_angle),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .o_res_valid    (core_res_valid),
        .i_res_ready    (core_res_ready),
        .o_res          (core_res)
    );

    // Output register: take a new result when empty or being drained.
    assign core_res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (core_res_valid && core_res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && core_res_ready) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_duty_a           = r_out.duty_a;
    assign o_duty_b           = r_out.duty_b;
    assign o_duty_c           = r_out.duty_c;
    assign o_speed_estimate   = r_out.speed_estimate;
    assign o_drive_command    = r_out.drive_command;
    assign o_electrical_angle = r_out.electrical_angle;

`ifndef SYNTHESIS
    // drive command respects ordered clamps
    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_cfg.drive_min <= r_cfg.drive_max) |->
            (o_drive_command >= r_cfg.drive_min) && (o_drive_command <= r_cfg.drive_max))
        else $error("drive command outside clamp range");

    // a table write never blocks the input
    a_table_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode |=> o_in_ready)
        else $error("table write left the block busy");

    // a control tick always occupies the sequencer
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_mode |=> !o_in_ready)
        else $error("tick accepted without starting the sequencer");
`endif

endmodule

[hdl/focsl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module focsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/focsl_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on focsl_pkg.
module focsl_mul import focsl_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_req                 i_req,
    output logic signed [MUL_PW-1:0] o_prod
);

    logic signed [MUL_PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_req.a) * $signed(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

[hdl/focsl_core.sv]
// Sequencer and datapath of the speed loop: correction table, speed filter,
// PI loop, inverse Park/Clarke and duty scaling. Depends on focsl_pkg,
// focsl_ram and focsl_mul.
module focsl_core import focsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [11:0]        i_sensor_angle,
    input  logic [CORR_AW-1:0] i_table_index,
    input  logic signed [15:0] i_table_value,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    t_state r_state, n_state;

    logic [11:0]        r_angle;
    logic [11:0]        r_prev;
    logic               r_first;
    logic signed [23:0] r_filt;
    logic signed [15:0] r_integ;
    logic signed [15:0] r_vq;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic [15:0]        r_tlo;
    logic [15:0]        r_elec;
    logic signed [12:0] r_delta;
    logic signed [24:0] r_diff;
    logic signed [24:0] r_err;
    logic signed [24:0] r_p;
    logic signed [31:0] r_valpha;
    logic [47:0]        r_u [3];
    logic [39:0]        r_ph;
    logic [1:0]         r_k;
    logic [12:0]        r_duty [3];

    logic                     accept;
    logic [CORR_AW-1:0]       ram_raddr;
    logic [15:0]              ram_rdata;
    t_mul_req                 mul_req;
    logic signed [MUL_PW-1:0] prod;

    logic signed [13:0] dd;
    logic signed [13:0] dwrap;
    logic [15:0]        dcorr;
    logic signed [17:0] dext;
    logic signed [17:0] fd;
    logic [15:0]        corr;
    logic [15:0]        elec;
    logic signed [23:0] raw;
    logic signed [24:0] diff;
    logic signed [23:0] filt_new;
    logic signed [24:0] err;
    logic signed [25:0] integ_sum;
    logic signed [15:0] integ_clamped;
    logic signed [25:0] vq_sum;
    logic signed [15:0] vq_clamped;
    logic signed [MUL_PW-1:0] va, vh, vb, vc;
    logic [39:0]        duty_sum;

    assign accept = i_in_valid & o_in_ready;

    focsl_ram #(.WIDTH(16), .DEPTH(CORRECTION_DEPTH)) u_corr_ram (
        .i_clk   (i_clk),
        .i_we    (accept & i_mode),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    focsl_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // low entry while idle, high entry (wrapping) after
    assign ram_raddr = (r_state == S_IDLE) ? i_sensor_angle[11:2]
                                           : r_angle[11:2] + 1'b1;

    function automatic logic signed [15:0] clamp16(input logic signed [25:0] x,
                                                   input logic signed [15:0] hi,
                                                   input logic signed [15:0] lo);
        logic signed [15:0] res;
        if (x > 26'(hi))      res = hi;
        else if (x < 26'(lo)) res = lo;
        else                  res = x[15:0];
        return res;
    endfunction

    function automatic logic [47:0] to_unipolar(input logic signed [MUL_PW-1:0] v);
        logic signed [MUL_PW-1:0] one;
        logic signed [MUL_PW-1:0] c;
        one = MUL_PW'(1) <<< 46;
        if (v > one)       c = one;
        else if (v < -one) c = -one;
        else               c = v;
        return 48'(c + one);
    endfunction

    always_comb begin
        dd = $signed({2'b00, r_angle}) - $signed({2'b00, r_prev});
        if (dd > 14'sd2048)       dwrap = dd - 14'sd4096;
        else if (dd < -14'sd2048) dwrap = dd + 14'sd4096;
        else                      dwrap = dd;

        dcorr = ram_rdata - r_tlo;
        dext  = 18'($signed(dcorr));
        fd    = (r_angle[0] ? dext : 18'sd0) + (r_angle[1] ? (dext <<< 1) : 18'sd0);
        corr  = r_tlo + 16'(fd >>> 2);
        elec  = 16'({4'b0000, r_angle} * MECH_SCALE) - i_cfg.electrical_offset + corr;

        if (prod > MUL_PW'(24'sh7FFFFF))      raw = 24'sh7FFFFF;
        else if (prod < -MUL_PW'(24'sh7FFFFF) - 1) raw = 24'sh800000;
        else                                   raw = prod[23:0];
        diff = 25'(raw) - 25'(r_filt);

        filt_new = 24'(MUL_PW'(r_filt) + (prod >>> 16));
        err      = 25'(i_cfg.speed_reference) - 25'(filt_new);

        integ_sum     = 26'(r_integ) + 26'(prod >>> 24);
        integ_clamped = clamp16(integ_sum, i_cfg.drive_max, i_cfg.drive_min);
        vq_sum        = 26'(r_p) + 26'(r_integ);
        vq_clamped    = clamp16(vq_sum, i_cfg.drive_max, i_cfg.drive_min);

        va = MUL_PW'(r_valpha) <<< 16;
        vh = -(MUL_PW'(r_valpha) <<< 15);
        vb = vh + prod;
        vc = vh - prod;

        duty_sum = r_ph + 40'(prod[39:0] >> 24);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (r_state)
            S_RDHI: begin
                mul_req.a = MUL_AW'(r_delta);
                mul_req.b = $signed({10'b0, i_cfg.speed_gain});
            end
            S_MF: begin
                mul_req.a = MUL_AW'(r_diff);
                mul_req.b = $signed({10'b0, i_cfg.filter_alpha});
            end
            S_MP: begin
                mul_req.a = MUL_AW'(r_err);
                mul_req.b = $signed({2'b0, i_cfg.prop_gain});
            end
            S_MI: begin
                mul_req.a = MUL_AW'(r_err);
                mul_req.b = $signed({2'b0, i_cfg.integral_gain_dt});
            end
            S_MS: begin
                mul_req.a = MUL_AW'(r_vq);
                mul_req.b = MUL_BW'(r_sin);
            end
            S_MC: begin
                mul_req.a = MUL_AW'(r_vq);
                mul_req.b = MUL_BW'(r_cos);
            end
            S_MB: begin
                mul_req.a = MUL_AW'($signed(prod[31:0]));
                mul_req.b = SQRT3_HALF_Q16;
            end
            S_MH: begin
                mul_req.a = $signed({10'b0, r_u[r_k][47:24]});
                mul_req.b = PWM_MUL;
            end
            S_ML: begin
                mul_req.a = $signed({10'b0, r_u[r_k][23:0]});
                mul_req.b = PWM_MUL;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && !i_mode) n_state = S_RDLO;
            end
            S_RDLO: n_state = S_RDHI;
            S_RDHI: n_state = r_first ? S_IDLE : S_SAT;
            S_SAT:  n_state = S_MF;
            S_MF:   n_state = S_FILT;
            S_FILT: n_state = S_MP;
            S_MP:   n_state = S_MI;
            S_MI:   n_state = S_INT;
            S_INT:  n_state = S_VQ;
            S_VQ:   n_state = S_MS;
            S_MS:   n_state = S_MC;
            S_MC:   n_state = S_MB;
            S_MB:   n_state = S_VABC;
            S_VABC: n_state = S_MH;
            S_MH:   n_state = S_ML;
            S_ML:   n_state = S_DUTY;
            S_DUTY: n_state = (r_k == 2'd2) ? S_DONE : S_MH;
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_prev  <= '0;
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept && !i_mode) r_angle <= i_sensor_angle;
                S_RDLO: begin
                    r_tlo   <= ram_rdata;
                    r_delta <= dwrap[12:0];
                end
                S_RDHI: begin
                    r_elec  <= elec;
                    r_prev  <= r_angle;
                    r_first <= 1'b0;
                end
                S_SAT:  r_diff <= diff;
                S_FILT: begin
                    r_filt <= filt_new;
                    r_err  <= err;
                end
                S_MI:   r_p <= 25'(prod >>> 24);
                S_INT:  r_integ <= integ_clamped;
                S_VQ: begin
                    r_vq  <= vq_clamped;
                    r_sin <= sine_at(r_elec);
                    r_cos <= sine_at(r_elec + 16'd16384);
                end
                S_MC:   r_valpha <= 32'(-prod);
                S_VABC: begin
                    r_u[0] <= to_unipolar(va);
                    r_u[1] <= to_unipolar(vb);
                    r_u[2] <= to_unipolar(vc);
                    r_k    <= 2'd0;
                end
                S_ML:   r_ph <= prod[39:0];
                S_DUTY: begin
                    r_duty[r_k] <= duty_sum[35:23];
                    r_k         <= r_k + 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.duty_a           = r_duty[0];
    assign o_res.duty_b           = r_duty[1];
    assign o_res.duty_c           = r_duty[2];
    assign o_res.speed_estimate   = r_filt;
    assign o_res.drive_command    = r_vq;
    assign o_res.electrical_angle = r_elec;

endmodule
